>>> rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the Sobel 3x3 edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  // Pixel and geometry widths
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 13;
  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = DIM_W;

  // Register reset values
  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Arithmetic widths: gradients span +/-1020, their square sum stays below 2^21
  localparam int GRAD_W  = 11;
  localparam int SUMSQ_W = 21;
  localparam int ROOT_W  = 8;
  localparam int BIT_W   = $clog2(ROOT_W);

  // Largest square sum that still rounds to a root of 255 (255*255 + 255)
  localparam logic [SUMSQ_W-1:0] SAT_LIMIT = SUMSQ_W'(65280);

  // Line store word: previous row in the low byte, the row before in the high byte
  localparam int LINE_W = 2 * PIX_W;

  // Controller to datapath commands
  typedef struct packed {
    logic             accept;     // latch pixel, read line stores
    logic             load;       // shift window, write line stores, advance position
    logic             square;     // form the square sum
    logic             root_step;  // one bit of the square root
    logic [BIT_W-1:0] root_bit;   // bit under trial
    logic             out_load;   // round and move result to output register
  } sem_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic emit;      // current position is interior
    logic out_free;  // output register can take a result this cycle
  } sem_sts_t;

endpackage

>>> rtl/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sem_ctrl.sv
// ----------------------------------------------------------------------------
// sem_ctrl
// Per-pixel sequencer: accept, window load, square sum, root bits, output.
// ----------------------------------------------------------------------------
module sem_ctrl
  import sem_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sem_sts_t sts_i,
  output sem_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQUARE,
    ST_ROOT,
    ST_OUT
  } state_e;

  state_e           state_q;
  logic [BIT_W-1:0] bit_q;

  // Sequence one pixel at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          // border positions give no result
          state_q <= sts_i.emit ? ST_SQUARE : ST_IDLE;
        end
        ST_SQUARE: begin
          state_q <= ST_ROOT;
          bit_q   <= BIT_W'(ROOT_W - 1);
        end
        ST_ROOT: begin
          if (bit_q == '0) begin
            state_q <= ST_OUT;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        ST_OUT: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Decode commands from state
  always_comb begin
    cmd_o           = '0;
    cmd_o.accept    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.load      = (state_q == ST_LOAD);
    cmd_o.square    = (state_q == ST_SQUARE);
    cmd_o.root_step = (state_q == ST_ROOT);
    cmd_o.root_bit  = bit_q;
    cmd_o.out_load  = (state_q == ST_OUT) && sts_i.out_free;
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

>>> rtl/sem_dp.sv
// ----------------------------------------------------------------------------
// sem_dp
// Datapath: line stores, 3x3 window, Sobel sums, bit-serial root, output stage.
// ----------------------------------------------------------------------------
module sem_dp
  import sem_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic [PIX_W-1:0]     pixel_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [PIX_W-1:0]     magnitude_o,
  output logic                 frame_last_o,
  input  sem_cmd_t             cmd_i,
  output sem_sts_t             sts_o
);

  logic [DIM_W-1:0]   width_q, height_q;
  logic [COL_W-1:0]   col_q, col_last;
  logic [ROW_W-1:0]   row_q, row_last;
  logic [PIX_W-1:0]   px_q;
  logic [LINE_W-1:0]  line_rd;
  logic [PIX_W-1:0]   win_q [9];
  logic [PIX_W-1:0]   win_d [9];
  logic signed [GRAD_W-1:0] p [9];
  logic signed [GRAD_W-1:0] v_d, h_d, v_q, h_q;
  logic signed [2*GRAD_W-1:0] v_sq, h_sq;
  logic [SUMSQ_W-1:0] n_q;
  logic [ROOT_W-1:0]  s_q, trial;
  logic [2*ROOT_W-1:0] trial_sq, s_sq;
  logic [2*ROOT_W:0]  round_thr;
  logic               round_up, last_q;
  logic [PIX_W-1:0]   mag_d;
  logic               out_valid_q, out_last_q;
  logic [PIX_W-1:0]   out_mag_q;

  // Effective geometry: width clamped to 3..MAX_WIDTH, height to at least 3
  always_comb begin
    if (width_q < DIM_W'(3)) begin
      col_last = COL_W'(2);
    end else if (width_q > DIM_W'(MAX_WIDTH)) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(width_q - 1'b1);
    end
    row_last = (height_q < DIM_W'(3)) ? ROW_W'(2) : height_q - 1'b1;
  end

  // Line stores for the two rows above
  sem_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load),
    .waddr_i(col_q),
    .wdata_i({line_rd[PIX_W-1:0], px_q}),
    .re_i   (cmd_i.accept),
    .raddr_i(col_q),
    .rdata_o(line_rd)
  );

  // Next window: shift left, new column from line stores and pixel
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3 + 0] = win_q[r*3 + 1];
      win_d[r*3 + 1] = win_q[r*3 + 2];
    end
    win_d[2] = line_rd[LINE_W-1:PIX_W];
    win_d[5] = line_rd[PIX_W-1:0];
    win_d[8] = px_q;
    for (int i = 0; i < 9; i++) begin
      p[i] = signed'({{(GRAD_W-PIX_W){1'b0}}, win_d[i]});
    end
    v_d = p[6] + (p[7] <<< 1) + p[8] - p[0] - (p[1] <<< 1) - p[2];
    h_d = p[2] + (p[5] <<< 1) + p[8] - p[0] - (p[3] <<< 1) - p[6];
  end

  // Configuration, position counters and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      col_q    <= '0;
      row_q    <= '0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      // a register write restarts the frame
      if (cfg_idx_i == REG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_idx_i == REG_IMAGE_HEIGHT) begin
        height_q <= cfg_data_i;
      end
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.load) begin
      win_q <= win_d;
      if (col_q == col_last) begin
        col_q <= '0;
        row_q <= (row_q == row_last) ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  assign sts_o.emit = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));

  // Hold pixel, gradients and frame-end flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      px_q <= pixel_i;
    end
    if (cmd_i.load) begin
      v_q    <= v_d;
      h_q    <= h_d;
      last_q <= (row_q == row_last) && (col_q == col_last);
    end
  end

  // Square sum, then one root bit per step
  assign v_sq     = v_q * v_q;
  assign h_sq     = h_q * h_q;
  assign trial    = s_q | (ROOT_W'(1) << cmd_i.root_bit);
  assign trial_sq = trial * trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      n_q <= SUMSQ_W'(v_sq) + SUMSQ_W'(h_sq);
      s_q <= '0;
    end else if (cmd_i.root_step) begin
      if (SUMSQ_W'(trial_sq) <= n_q) begin
        s_q <= trial;
      end
    end
  end

  // Round up when n exceeds s*s + s; saturate above 255
  assign s_sq      = s_q * s_q;
  assign round_thr = {1'b0, s_sq} + (2*ROOT_W+1)'(s_q);
  assign round_up  = n_q > SUMSQ_W'(round_thr);
  assign mag_d     = (n_q > SAT_LIMIT) ? {PIX_W{1'b1}} : s_q + PIX_W'(round_up);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_mag_q  <= mag_d;
      out_last_q <= last_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign magnitude_o    = out_mag_q;
  assign frame_last_o   = out_last_q;

endmodule

>>> rtl/sobel_edge_magnitude_3x3.sv
// A pixel is taken only while the block is idle; it then passes the window load,
//   and an interior pixel also the square sum, the 8-step bit-serial square root
//   and the output register load, which waits while the output stalls.
// Reset (rst_ni, asynchronous, active low) clears control, position and window,
//   and loads width 640 and height 480; the line stores are not cleared.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_3x3
// Sobel 3x3 gradient magnitude over a raster pixel stream.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3
  import sem_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  // pixel stream in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] pixel
  // magnitude stream out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] magnitude
  output logic                 m_axis_tlast    // frame_last
);

  sem_cmd_t cmd;
  sem_sts_t sts;

  // Sequencer
  sem_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Datapath
  sem_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_i     (s_axis_tdata[PIX_W-1:0]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .magnitude_o (m_axis_tdata[PIX_W-1:0]),
    .frame_last_o(m_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> rtl/sem_checker.sv
// ----------------------------------------------------------------------------
// sem_checker
// Port-level checks for the Sobel edge magnitude block, bound to the top.
// ----------------------------------------------------------------------------
module sem_checker
  import sem_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [DIM_W-1:0]     cfg_data_i,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [7:0]           s_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [7:0]           m_axis_tdata,
  input logic                 m_axis_tlast
);

  logic        in_xfer, out_xfer;
  logic [31:0] pending_q;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Count pixels transferred in and not yet answered by a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (cfg_we_i && !in_xfer && !out_xfer) begin
      pending_q <= pending_q;
    end else begin
      pending_q <= pending_q + 32'(in_xfer) - 32'(out_xfer);
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // One pixel at a time: ready drops after each transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("pixel taken while previous one in work");

  // A new result is only loaded while the input side is busy
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without work in progress");

  // Never more results than pixels
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> pending_q != '0)
    else $error("result without a matching pixel");

endmodule

bind sobel_edge_magnitude_3x3 sem_checker u_sem_checker (.*);

>>> tb/sobel_edge_magnitude_3x3_tb.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_3x3_tb
// Self-checking bench for the Sobel 3x3 edge magnitude block. A clocked
// driver streams pixels from a queue, and a built-in line store and window
// model predicts every magnitude and frame flag. A clocked monitor compares
// each output transfer with the oldest prediction. Geometry is changed only
// while the block is idle. The run covers the reset size, a stretch with no
// idling, clamped sizes, an oversized height register, and random content
// and sizes.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3_tb;
  import sem_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS  = 440;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef enum int {
    CONTENT_UNIFORM,
    CONTENT_BINARY,
    CONTENT_SMOOTH
  } content_e;

  typedef struct packed {
    logic [PIX_W-1:0] magnitude;
    logic             frame_last;
  } edge_res_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = REG_IMAGE_WIDTH;
  logic [DIM_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;  // [7:0] pixel
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;        // [7:0] magnitude
  logic                 m_axis_tlast;        // frame_last

  // Stimulus and expectation stores
  logic [PIX_W-1:0] pixel_q[$];
  edge_res_t        mag_expected_q[$];
  edge_res_t        want_res;
  logic             idle_en        = 1'b0;
  int unsigned      mismatch_count = 0;
  int unsigned      rand_items     = 0;
  int               smooth_level   = 128;

  // Predictor state
  logic [PIX_W-1:0] above_row  [MAX_WIDTH];
  logic [PIX_W-1:0] above2_row [MAX_WIDTH];
  logic [PIX_W-1:0] win [9];  // [row*3 + col], row 0 oldest, col 2 newest
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;

  sobel_edge_magnitude_3x3 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Rounded integer square root, saturated to one byte
  function automatic logic [PIX_W-1:0] rounded_root(input int unsigned n);
    int unsigned s = 0;
    int unsigned t;
    for (int b = 15; b >= 0; b--) begin
      t = s | (32'd1 << b);
      if (t * t <= n) s = t;
    end
    if (n > s * s + s) s++;
    return (s > 255) ? 8'd255 : s[PIX_W-1:0];
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg < 3) ? 3 : int'(height_reg);
  endfunction

  function automatic void clear_geometry_model();
    foreach (win[i]) win[i] = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
  endfunction

  // A register write also restarts the frame; line stores keep their content
  function automatic void apply_geometry_write(input logic [CFG_IDX_W-1:0] idx,
                                               input logic [DIM_W-1:0] val);
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Shift the window, update the line stores and predict the magnitude
  function automatic void predict_pixel(input logic [PIX_W-1:0] px);
    int unsigned w = eff_width();
    int unsigned h = eff_height();
    int unsigned c = col_pos;
    int unsigned r = row_pos;
    int unsigned n;
    int          v;
    int          hz;
    edge_res_t   res;
    for (int i = 0; i < 3; i++) begin
      win[i*3]     = win[i*3 + 1];
      win[i*3 + 1] = win[i*3 + 2];
    end
    win[2]        = above2_row[c];
    win[5]        = above_row[c];
    win[8]        = px;
    above2_row[c] = above_row[c];
    above_row[c]  = px;
    if (r >= 2 && c >= 2) begin
      v  = -int'(win[0]) - 2 * int'(win[1]) - int'(win[2])
         +  int'(win[6]) + 2 * int'(win[7]) + int'(win[8]);
      hz = -int'(win[0]) - 2 * int'(win[3]) - int'(win[6])
         +  int'(win[2]) + 2 * int'(win[5]) + int'(win[8]);
      n  = v * v + hz * hz;
      res.magnitude  = rounded_root(n);
      res.frame_last = (r == h - 1) && (c == w - 1);
      mag_expected_q.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  // Pixel driver: predict on each accepted transfer, then present the next
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_pixel(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_q.size() != 0 && !(idle_en && $urandom_range(0, 99) < 25)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pixel_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Magnitude monitor: stall at random, check each transfer in order
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(idle_en && $urandom_range(0, 99) < 25);
      if (m_axis_tvalid && m_axis_tready) begin
        if (mag_expected_q.size() == 0) begin
          $error("unexpected result: magnitude %0d frame_last %0b",
                 m_axis_tdata, m_axis_tlast);
          mismatch_count++;
        end else begin
          want_res = mag_expected_q.pop_front();
          if (m_axis_tdata !== want_res.magnitude) begin
            $error("magnitude: expected %0d, got %0d", want_res.magnitude, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tlast !== want_res.frame_last) begin
            $error("frame_last: expected %0b, got %0b", want_res.frame_last, m_axis_tlast);
            mismatch_count++;
          end
        end
      end
    end
  end

  function automatic logic [PIX_W-1:0] next_pixel(input content_e mode);
    case (mode)
      CONTENT_BINARY: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      CONTENT_SMOOTH: begin
        smooth_level += int'($urandom_range(0, 16)) - 8;
        if (smooth_level < 0) smooth_level = 0;
        if (smooth_level > 255) smooth_level = 255;
        return smooth_level[PIX_W-1:0];
      end
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_pixels(input int unsigned count, input content_e mode);
    @(negedge clk_i);
    for (int unsigned i = 0; i < count; i++) pixel_q.push_back(next_pixel(mode));
  endtask

  // Hold until the sender is empty and no result is outstanding
  task automatic wait_drained();
    @(negedge clk_i);
    while (pixel_q.size() != 0 || s_axis_tvalid || mag_expected_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Drained, then let trailing border pixels leave the pipeline
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    apply_geometry_write(idx, val);
  endtask

  task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // Run limit
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Main sequence
  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned count;
    int unsigned phase_no;
    content_e    mode;
    clear_geometry_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: part of the first row only, so no result may appear
    idle_en = 1'b0;
    push_pixels(20, CONTENT_UNIFORM);
    rand_items += 20;

    // One small frame with no idling on either side
    set_geometry(DIM_W'(12), DIM_W'(5));
    push_pixels(60, CONTENT_UNIFORM);
    rand_items += 60;
    wait_drained();
    idle_en = 1'b1;

    // Smallest frame: flat white, hard horizontal edge, gentle ramp
    set_geometry(DIM_W'(3), DIM_W'(3));
    @(negedge clk_i);
    repeat (9) pixel_q.push_back(8'd255);
    repeat (6) pixel_q.push_back(8'd0);
    repeat (3) pixel_q.push_back(8'd255);
    for (int i = 1; i <= 9; i++) pixel_q.push_back(PIX_W'(i * 28));
    rand_items += 27;

    // Sizes below the minimum clamp to three
    set_geometry(DIM_W'(1), DIM_W'(2));
    push_pixels(18, CONTENT_UNIFORM);
    rand_items += 18;
    set_geometry(DIM_W'(0), DIM_W'(0));
    push_pixels(9, CONTENT_BINARY);
    rand_items += 9;

    // Random sizes and content
    phase_no = 0;
    while (rand_items < RANDOM_ITEMS) begin
      wait_idle();
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      case ($urandom_range(0, 3))
        0: write_reg(REG_IMAGE_WIDTH, DIM_W'(w));
        1: write_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
        default: begin
          write_reg(REG_IMAGE_WIDTH, DIM_W'(w));
          write_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
        end
      endcase
      mode    = content_e'($urandom_range(0, 2));
      idle_en = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) == 0)
        count = $urandom_range(1, 2 * eff_width() * eff_height());
      else
        count = eff_width() * eff_height() * $urandom_range(1, 3);
      if (count > RANDOM_ITEMS - rand_items) count = RANDOM_ITEMS - rand_items;
      if (phase_no == 0) begin
        // Pause mid-frame until every outstanding result has arrived
        push_pixels(count / 2, mode);
        wait_drained();
        push_pixels(count - count / 2, mode);
      end else begin
        push_pixels(count, mode);
      end
      rand_items += count;
      phase_no++;
    end
    idle_en = 1'b1;

    // Height register at its top: a few rows only
    set_geometry(DIM_W'(5), DIM_W'(8191));
    push_pixels(5 * 12, CONTENT_UNIFORM);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sobel_edge_magnitude_3x3.f
rtl/sem_pkg.sv
rtl/sem_ram.sv
rtl/sem_ctrl.sv
rtl/sem_dp.sv
rtl/sobel_edge_magnitude_3x3.sv
rtl/sem_checker.sv
tb/sobel_edge_magnitude_3x3_tb.sv
